/* design/crc8cfb_pkg.sv */
// Shared types, codes and constants of the CRC-8 control frame builder.
`default_nettype none
package crc8cfb_pkg;

   // Widths of the packed stream payloads
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 168;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Frame layout
   localparam int          FRAME_LEN     = 16;
   localparam int          BYTE_IDX_W    = 4;
   localparam logic [7:0]  SYNC_BYTE_0   = 8'hA5;
   localparam logic [7:0]  SYNC_BYTE_1   = 8'h5A;
   localparam logic [7:0]  FRAME_VERSION = 8'h01;
   localparam logic [7:0]  CRC_POLY      = 8'h07;
   localparam logic [7:0]  CRC_INIT      = 8'h00;
   localparam logic [3:0]  KEY_HIGH_MASK = 4'hF;

   // Register index of the link-ready flag (word address bit 2)
   localparam logic CSR_IDX_LINK_READY = 1'b0;

   // Command codes carried on the request tuser
   localparam logic CMD_SEND    = 1'b0;
   localparam logic CMD_OUTCOME = 1'b1;

   typedef enum logic [1:0] {
      KIND_FRAME     = 2'd0,
      KIND_NOT_READY = 2'd1,
      KIND_BUSY      = 2'd2,
      KIND_OUTCOME   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0] left_trigger;
      logic [15:0] right_trigger;
      logic [7:0]  left_x;
      logic [7:0]  left_y;
      logic [7:0]  right_x;
      logic [7:0]  right_y;
      logic [7:0]  switch_byte;
      logic [11:0] key_word;
      logic        adc_fault;
   } snapshot_type;

   typedef struct packed {
      logic send;
      logic not_ready;
      logic busy;
      logic sent_ok;
      logic failed;
   } stats_event_type;

   typedef struct packed {
      logic [31:0] tx_failures;
      logic [31:0] ready_skips;
      logic [31:0] busy_skips;
      logic [31:0] frames_sent;
      logic [31:0] attempts;
   } stats_type;

   // One byte of a CRC-8, MSB first, no reflection
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* design/crc8_control_frame_builder_core.sv */
// Top level of the CRC-8 control frame builder: item register, control and result register.
`default_nettype none
//
//  Channel   Port group  Direction  Contents
//  --------  ----------  ---------  ---------------------------------------------------
//  request   req_*       in         one send request or transmit outcome report
//  response  rsp_*       out        frame bytes, skip status or outcome status
//  config    csr_*       in/out     APB-style access to the link-ready register
//
// A send request that builds a frame occupies the block for its sixteen bytes, one
// byte per cycle while rsp_tready allows, from the serializer into the result
// register. Skips and outcome reports yield one result each and flow back to back.
// A request enters the item register, its results the result register. Reset
// clears the counters, the sequence number and link_ready; a stall on rsp_tready
// holds the result register and, through it, the item register and the serializer.
//
module crc8_control_frame_builder_core #(
   parameter int SWITCH_COUNT = 8,
   parameter int KEY_COUNT    = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata, lowest bit first: aux_busy, left_trigger, right_trigger, left_x,
   // left_y, right_x, right_y, switch_bits, key_bits, adc_fault, tx_ok, one pad bit
   input  wire logic [crc8cfb_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd
   input  wire logic                              req_tuser,
   // Response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata, lowest bit first: frame_byte, attempts, frames_sent, busy_skips,
   // ready_skips, tx_failures
   output logic      [crc8cfb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: kind
   output logic      [1:0]                         rsp_tuser,
   output logic                                   rsp_tlast,
   // Configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [crc8cfb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [crc8cfb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [crc8cfb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import crc8cfb_pkg::*;

   // Item register. Only the switch and key bits that exist are stored.
   logic                    item_valid_ff;
   logic                    item_valid_in;
   logic                    cmd_ff;
   logic                    aux_busy_ff;
   logic                    tx_ok_ff;
   logic                    adc_fault_ff;
   logic [15:0]             left_trigger_ff;
   logic [15:0]             right_trigger_ff;
   logic [7:0]              left_x_ff;
   logic [7:0]              left_y_ff;
   logic [7:0]              right_x_ff;
   logic [7:0]              right_y_ff;
   logic [SWITCH_COUNT-1:0] switch_ff;
   logic [KEY_COUNT-1:0]    key_ff;

   // Result register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   kind_type    kind_ff;
   kind_type    kind_in;
   logic [7:0]  byte_ff;
   logic [7:0]  byte_in;
   logic        last_ff;
   logic        last_in;
   stats_type   stats_ff;

   logic            link_ready;
   logic            out_free;
   logic            emit;
   logic            is_frame;
   logic            item_done;
   logic            ser_first;
   logic            ser_last;
   logic [7:0]      ser_byte;
   logic [7:0]      seq;
   logic            stats_update;
   stats_event_type ev;
   stats_type       stats_next;
   snapshot_type    snap;
   logic            req_load;

   crc8cfb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .link_ready  (link_ready)
   );

   // The result register can take a new value when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = item_valid_ff && out_free;

   // A send request builds a frame only with the link up and the radio idle;
   // a not-ready link wins over a busy radio.
   assign is_frame = (cmd_ff == CMD_SEND) && link_ready && !aux_busy_ff;

   // The item leaves the register with its last result.
   assign item_done = emit && (!is_frame || ser_last);

   // A new request transfer is taken whenever the item register frees up this cycle.
   assign req_tready = !item_valid_ff || item_done;
   assign req_load   = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_load) begin
         item_valid_in = 1'b1;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         cmd_ff           <= req_tuser;
         aux_busy_ff      <= req_tdata[0];
         left_trigger_ff  <= req_tdata[16:1];
         right_trigger_ff <= req_tdata[32:17];
         left_x_ff        <= req_tdata[40:33];
         left_y_ff        <= req_tdata[48:41];
         right_x_ff       <= req_tdata[56:49];
         right_y_ff       <= req_tdata[64:57];
         switch_ff        <= req_tdata[65 +: SWITCH_COUNT];
         key_ff           <= req_tdata[73 +: KEY_COUNT];
         adc_fault_ff     <= req_tdata[85];
         tx_ok_ff         <= req_tdata[86];
      end
   end

   // Switch and key bits beyond the configured counts read as zero.
   always_comb begin
      snap.left_trigger  = left_trigger_ff;
      snap.right_trigger = right_trigger_ff;
      snap.left_x        = left_x_ff;
      snap.left_y        = left_y_ff;
      snap.right_x       = right_x_ff;
      snap.right_y       = right_y_ff;
      snap.switch_byte   = 8'(switch_ff);
      snap.key_word      = 12'(key_ff);
      snap.adc_fault     = adc_fault_ff;
   end

   crc8cfb_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .step     (emit && is_frame),
      .seq      (seq),
      .snap     (snap),
      .byte_out (ser_byte),
      .first    (ser_first),
      .last     (ser_last)
   );

   // Counters move with the first result of an item; every later frame byte
   // carries the same, already updated, values.
   assign stats_update = emit && (!is_frame || ser_first);

   always_comb begin
      ev.send      = (cmd_ff == CMD_SEND);
      ev.not_ready = (cmd_ff == CMD_SEND) && !link_ready;
      ev.busy      = (cmd_ff == CMD_SEND) && link_ready && aux_busy_ff;
      ev.sent_ok   = (cmd_ff == CMD_OUTCOME) && tx_ok_ff;
      ev.failed    = (cmd_ff == CMD_OUTCOME) && !tx_ok_ff;
   end

   crc8cfb_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .update     (stats_update),
      .ev         (ev),
      .stats_next (stats_next),
      .seq        (seq)
   );

   always_comb begin
      if (cmd_ff == CMD_OUTCOME) begin
         kind_in = KIND_OUTCOME;
      end else if (!link_ready) begin
         kind_in = KIND_NOT_READY;
      end else if (aux_busy_ff) begin
         kind_in = KIND_BUSY;
      end else begin
         kind_in = KIND_FRAME;
      end
      byte_in = is_frame ? ser_byte : 8'h00;
      last_in = is_frame ? ser_last : 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         last_ff  <= last_in;
         stats_ff <= stats_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {stats_ff.tx_failures, stats_ff.ready_skips, stats_ff.busy_skips,
                        stats_ff.frames_sent, stats_ff.attempts, byte_ff};

endmodule
`default_nettype wire

/* design/crc8cfb_csr.sv */
// Configuration register block with an APB-style write and read port.
`default_nettype none
module crc8cfb_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [crc8cfb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [crc8cfb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [crc8cfb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready,
   output logic                                   link_ready
);
   import crc8cfb_pkg::*;

   logic link_ready_ff;
   logic link_ready_in;
   logic write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_LINK_READY);

   always_comb begin
      link_ready_in = link_ready_ff;
      if (write_hit) begin
         link_ready_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ready_ff <= 1'b0;
      end else begin
         link_ready_ff <= link_ready_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_LINK_READY) begin
         csr_prdata = CSR_DATA_W'(link_ready_ff);
      end
   end

   assign link_ready = link_ready_ff;

endmodule
`default_nettype wire

/* design/crc8cfb_stats.sv */
// Sequence number and the wrapping transmit statistics counters.
`default_nettype none
module crc8cfb_stats (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         update,
   input  wire crc8cfb_pkg::stats_event_type ev,
   output crc8cfb_pkg::stats_type            stats_next,
   output logic [7:0]                        seq
);
   import crc8cfb_pkg::*;

   stats_type  stats_ff;
   stats_type  stats_in;
   logic [7:0] seq_ff;
   logic [7:0] seq_in;

   always_comb begin
      stats_in = stats_ff;
      seq_in   = seq_ff;
      if (update) begin
         if (ev.send) begin
            stats_in.attempts = stats_ff.attempts + 32'd1;
         end
         if (ev.not_ready) begin
            stats_in.ready_skips = stats_ff.ready_skips + 32'd1;
         end
         if (ev.busy) begin
            stats_in.busy_skips = stats_ff.busy_skips + 32'd1;
         end
         if (ev.sent_ok) begin
            stats_in.frames_sent = stats_ff.frames_sent + 32'd1;
            seq_in               = seq_ff + 8'd1;
         end
         if (ev.failed) begin
            stats_in.tx_failures = stats_ff.tx_failures + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= '0;
         seq_ff   <= '0;
      end else begin
         stats_ff <= stats_in;
         seq_ff   <= seq_in;
      end
   end

   assign stats_next = stats_in;
   assign seq        = seq_ff;

endmodule
`default_nettype wire

/* design/crc8cfb_serializer.sv */
// Frame byte serializer with a running CRC-8 over the header and payload bytes.
`default_nettype none
module crc8cfb_serializer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic [7:0]                seq,
   input  wire crc8cfb_pkg::snapshot_type snap,
   output logic [7:0]                     byte_out,
   output logic                           first,
   output logic                           last
);
   import crc8cfb_pkg::*;

   logic [BYTE_IDX_W-1:0] idx_ff;
   logic [BYTE_IDX_W-1:0] idx_in;
   logic [7:0]            crc_ff;
   logic [7:0]            crc_in;

   always_comb begin
      case (idx_ff)
         4'd0:    byte_out = SYNC_BYTE_0;
         4'd1:    byte_out = SYNC_BYTE_1;
         4'd2:    byte_out = FRAME_VERSION;
         4'd3:    byte_out = seq;
         4'd4:    byte_out = snap.left_trigger[7:0];
         4'd5:    byte_out = snap.left_trigger[15:8];
         4'd6:    byte_out = snap.right_trigger[7:0];
         4'd7:    byte_out = snap.right_trigger[15:8];
         4'd8:    byte_out = snap.left_x;
         4'd9:    byte_out = snap.left_y;
         4'd10:   byte_out = snap.right_x;
         4'd11:   byte_out = snap.right_y;
         4'd12:   byte_out = snap.switch_byte;
         4'd13:   byte_out = snap.key_word[7:0];
         4'd14:   byte_out = {snap.adc_fault, 3'b000, snap.key_word[11:8] & KEY_HIGH_MASK};
         default: byte_out = crc_ff;
      endcase
   end

   assign first = (idx_ff == '0);
   assign last  = (idx_ff == BYTE_IDX_W'(FRAME_LEN - 1));

   // The final byte is the CRC itself, so the register restarts after it.
   always_comb begin
      idx_in = idx_ff;
      crc_in = crc_ff;
      if (step) begin
         if (last) begin
            idx_in = '0;
            crc_in = CRC_INIT;
         end else begin
            idx_in = idx_ff + 1'b1;
            crc_in = crc8_step(crc_ff, byte_out);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         crc_ff <= CRC_INIT;
      end else begin
         idx_ff <= idx_in;
         crc_ff <= crc_in;
      end
   end

endmodule
`default_nettype wire

/* dv/crc8_frame_checker.sv */
// Checker for the CRC-8 control frame builder: predicts every result transfer and compares it.
module crc8_frame_checker #(
   parameter int SWITCH_COUNT = 8,
   parameter int KEY_COUNT    = 12
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [crc8cfb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                               req_tuser,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [crc8cfb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [1:0]                         rsp_tuser,
   input  wire logic                               rsp_tlast,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [crc8cfb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [crc8cfb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [crc8cfb_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                               csr_pready,
   output int                                      failures,
   output int                                      outstanding,
   output int                                      frames_seen,
   output int                                      skips_seen,
   output int                                      outcomes_seen
);
   import crc8cfb_pkg::*;

   localparam logic [7:0] SYNC_A        = 8'hA5;
   localparam logic [7:0] SYNC_B        = 8'h5A;
   localparam logic [7:0] VERSION       = 8'h01;
   localparam logic [7:0] POLY          = 8'h07;
   localparam logic [7:0] FAULT_FLAG    = 8'h80;
   localparam logic [3:0] KEY_HIGH_BITS = 4'hF;
   localparam int         FRAME_BYTES   = 16;
   localparam logic [CSR_ADDR_W-1:0] LINK_READY_ADDR = {CSR_IDX_LINK_READY, 2'b00};

   typedef struct packed {
      kind_type   kind;
      logic [7:0] frame_byte;
      logic       last;
      stats_type  stats;
   } result_type;

   result_type awaited_results[$];
   logic       link_ready;
   logic [7:0] sequence_number;
   stats_type  counters;

   // Bitwise CRC over bytes 0 to 14, most significant bit first.
   function automatic logic [7:0] crc8_of_header(input logic [FRAME_BYTES-1:0][7:0] frame);
      logic [7:0] crc;
      logic       feedback;
      crc = 8'h00;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         for (int b = 7; b >= 0; b--) begin
            feedback = crc[7] ^ frame[i][b];
            crc = {crc[6:0], 1'b0} ^ (feedback ? POLY : 8'h00);
         end
      end
      return crc;
   endfunction

   task automatic await_result(input kind_type kind, input logic [7:0] frame_byte,
                               input logic last);
      result_type r;
      r.kind       = kind;
      r.frame_byte = frame_byte;
      r.last       = last;
      r.stats      = counters;
      awaited_results.push_back(r);
   endtask

   task automatic predict_results(input logic cmd, input logic [REQ_DATA_W-1:0] item);
      logic [FRAME_BYTES-1:0][7:0] frame;
      logic [11:0]                 keys;
      keys = item[84:73] & 12'((1 << KEY_COUNT) - 1);
      if (cmd == CMD_OUTCOME) begin
         if (item[86]) begin
            sequence_number = sequence_number + 8'd1;
            counters.frames_sent = counters.frames_sent + 32'd1;
         end else begin
            counters.tx_failures = counters.tx_failures + 32'd1;
         end
         await_result(KIND_OUTCOME, 8'h00, 1'b1);
      end else begin
         counters.attempts = counters.attempts + 32'd1;
         if (!link_ready) begin
            counters.ready_skips = counters.ready_skips + 32'd1;
            await_result(KIND_NOT_READY, 8'h00, 1'b1);
         end else if (item[0]) begin
            counters.busy_skips = counters.busy_skips + 32'd1;
            await_result(KIND_BUSY, 8'h00, 1'b1);
         end else begin
            frame[0]  = SYNC_A;
            frame[1]  = SYNC_B;
            frame[2]  = VERSION;
            frame[3]  = sequence_number;
            frame[4]  = item[8:1];
            frame[5]  = item[16:9];
            frame[6]  = item[24:17];
            frame[7]  = item[32:25];
            frame[8]  = item[40:33];
            frame[9]  = item[48:41];
            frame[10] = item[56:49];
            frame[11] = item[64:57];
            frame[12] = item[72:65] & 8'((1 << SWITCH_COUNT) - 1);
            frame[13] = keys[7:0];
            frame[14] = (keys[11:8] & KEY_HIGH_BITS) | (item[85] ? FAULT_FLAG : 8'h00);
            frame[15] = crc8_of_header(frame);
            for (int k = 0; k < FRAME_BYTES; k++)
               await_result(KIND_FRAME, frame[k], k == FRAME_BYTES - 1);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic compare_result();
      result_type want;
      stats_type  got;
      if (awaited_results.size() == 0) begin
         $error("unexpected result: kind %0d, byte 0x%0h", rsp_tuser, rsp_tdata[7:0]);
         failures++;
      end else begin
         want = awaited_results.pop_front();
         got  = rsp_tdata[RSP_DATA_W-1:8];
         check_field("kind", want.kind, rsp_tuser);
         check_field("frame_byte", want.frame_byte, rsp_tdata[7:0]);
         check_field("last", want.last, rsp_tlast);
         check_field("attempts", want.stats.attempts, got.attempts);
         check_field("frames_sent", want.stats.frames_sent, got.frames_sent);
         check_field("busy_skips", want.stats.busy_skips, got.busy_skips);
         check_field("ready_skips", want.stats.ready_skips, got.ready_skips);
         check_field("tx_failures", want.stats.tx_failures, got.tx_failures);
         if (want.last) begin
            case (want.kind)
               KIND_FRAME:   frames_seen++;
               KIND_OUTCOME: outcomes_seen++;
               default:      skips_seen++;
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         link_ready      = 1'b0;
         sequence_number = 8'h00;
         counters        = '0;
         awaited_results.delete();
         failures        = 0;
         frames_seen     = 0;
         skips_seen      = 0;
         outcomes_seen   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            compare_result();
         if (req_tvalid && req_tready)
            predict_results(req_tuser, req_tdata);
         if (csr_psel && csr_penable && csr_pready && csr_paddr == LINK_READY_ADDR) begin
            if (csr_pwrite)
               link_ready = csr_pwdata[0];
            else
               check_field("link_ready readback", {31'b0, link_ready}, csr_prdata);
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

/* dv/crc8_control_frame_builder_core_test.sv */
// Testbench top for the CRC-8 control frame builder: clock, reset, stimulus and verdict.
module crc8_control_frame_builder_core_test;
   import crc8cfb_pkg::*;

   // Address of the link-ready register: word index in bit 2.
   localparam logic [CSR_ADDR_W-1:0] LINK_READY_ADDR = {CSR_IDX_LINK_READY, 2'b00};
   localparam int IDLE_PERCENT      = 21;
   localparam int RSP_HOLD_CYCLES   = 150;
   localparam int SETTLE_CYCLES     = 20;
   localparam logic [95:0] ALT_BITS = {48{2'b10}};

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int outstanding;
   int frames_seen;
   int skips_seen;
   int outcomes_seen;
   int requests_sent;

   // While set, neither side of the streams inserts idle cycles.
   bit burst_mode;
   // Each increment asks the result-side process for one long hold-off.
   int rsp_hold_requests;

   crc8_control_frame_builder_core i_dut (.*);

   crc8_frame_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well beyond the slowest legitimate run.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Result-side back-pressure. Ready drops at random, except during a burst, and
   // on request it stays low for a long stretch so that the block backs up and
   // eventually refuses further request transfers.
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_requests > holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= burst_mode || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Mostly random snapshots, with the occasional all-zero or all-one one so that
   // the extremes of every field turn up throughout the run.
   function automatic snapshot_type random_snapshot();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return bits[84:0];
      endcase
   endfunction

   // Offers one request and returns on the falling edge after its transfer.
   // Valid is only lowered for an idle gap, never between two back-to-back items.
   task automatic push_request(input logic cmd, input logic aux_busy,
                               input snapshot_type snap, input logic tx_ok);
      while (!burst_mode && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, tx_ok, snap.adc_fault, snap.key_word, snap.switch_byte,
                     snap.right_y, snap.right_x, snap.left_y, snap.left_x,
                     snap.right_trigger, snap.left_trigger, aux_busy};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted result has been seen. Every
   // request produces at least one result, so an empty queue means the block is idle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   // One APB transfer to the link-ready register, followed by a quiet pause.
   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= LINK_READY_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Writes the register while the block is idle and reads it back; the checker
   // compares the read data.
   task automatic set_link_ready(input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
   endtask

   // Mostly well-formed traffic: a send request followed by its outcome report.
   // The remainder is lone outcome reports and send requests that never get one.
   task automatic random_traffic(input int count);
      int issued;
      int pick;
      issued = 0;
      while (issued < count) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            push_request(CMD_SEND, $urandom_range(7) == 0, random_snapshot(),
                         1'($urandom_range(1)));
            push_request(CMD_OUTCOME, 1'($urandom_range(1)), random_snapshot(),
                         $urandom_range(3) != 0);
            issued += 2;
         end else if (pick < 88) begin
            push_request(CMD_OUTCOME, 1'($urandom_range(1)), random_snapshot(),
                         1'($urandom_range(1)));
            issued++;
         end else begin
            push_request(CMD_SEND, 1'($urandom_range(1)), random_snapshot(),
                         1'($urandom_range(1)));
            issued++;
         end
      end
   endtask

   initial begin
      snapshot_type pattern;
      pattern           = ALT_BITS[84:0];
      req_tvalid        = 1'b0;
      req_tuser         = CMD_SEND;
      req_tdata         = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      burst_mode        = 1'b0;
      rsp_hold_requests = 0;
      requests_sent     = 0;
      reset             = 1'b1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Link not ready out of reset: every send request is a not-ready skip, and
      // that skip wins over a busy radio.
      push_request(CMD_SEND, 1'b0, '0, 1'b0);
      push_request(CMD_SEND, 1'b1, '1, 1'b1);
      // Outcome reports with no frame pending are applied all the same; the
      // snapshot and busy flag they carry must be ignored.
      push_request(CMD_OUTCOME, 1'b0, '0, 1'b0);
      push_request(CMD_OUTCOME, 1'b1, '1, 1'b1);

      // Only bit 0 of the written word is meant to matter.
      set_link_ready(32'hFFFF_FFFF);
      // Frames at the field extremes and with alternating bit patterns; tx_ok is
      // ignored by send requests. The last one meets a busy radio and is skipped.
      push_request(CMD_SEND, 1'b0, '0, 1'b1);
      push_request(CMD_SEND, 1'b0, '1, 1'b0);
      push_request(CMD_SEND, 1'b0, pattern, 1'b0);
      push_request(CMD_SEND, 1'b0, ~pattern, 1'b1);
      push_request(CMD_SEND, 1'b1, random_snapshot(), 1'b0);
      // The sequence number in a frame is the one at request time; only a
      // successful outcome moves it on, a failed one merely counts.
      push_request(CMD_OUTCOME, 1'b0, '1, 1'b1);
      push_request(CMD_SEND, 1'b0, random_snapshot(), 1'b0);
      push_request(CMD_OUTCOME, 1'b1, '0, 1'b0);
      push_request(CMD_SEND, 1'b0, random_snapshot(), 1'b0);

      // Random phase with the link up. It opens with a long result hold-off while
      // frame requests keep coming, inside a stretch with no idling on either side.
      burst_mode        <= 1'b1;
      rsp_hold_requests <= rsp_hold_requests + 1;
      repeat (12) push_request(CMD_SEND, 1'b0, random_snapshot(), 1'($urandom_range(1)));
      random_traffic(40);
      burst_mode <= 1'b0;
      random_traffic(50);
      // The sender goes quiet until everything outstanding has come back.
      drain_results();
      random_traffic(40);

      // Link down again, written with every bit but bit 0 set.
      set_link_ready(32'hFFFF_FFFE);
      random_traffic(30);

      // And back up with the smallest word that enables it.
      set_link_ready(32'h0000_0001);
      random_traffic(65);

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d request transfers over three link settings,", requests_sent);
      $display("random idling and a long result stall: %0d frames, %0d skips, %0d outcomes.",
               frames_seen, skips_seen, outcomes_seen);
      if (failures == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
